// File: hw/rtl/scr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_pkg: shared types and constants
// Sizes, command codes, the item structs and the search result struct.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int Capacity = 64;
  localparam int SlotBits = $clog2(Capacity);
  localparam int CountBits = $clog2(Capacity + 1);
  localparam int KeyBits = 32;

  localparam logic [1:0] CMD_ACCESS = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [KeyBits-1:0] key;
  } scr_in_t;

  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [KeyBits-1:0] evicted_key;
    logic               removed;
  } scr_out_t;

  // Result of one search pass over the slot array.
  typedef struct packed {
    logic                hit;
    logic [SlotBits-1:0] hit_slot;
    logic                free_found;
    logic [SlotBits-1:0] free_slot;
  } scr_search_t;

endpackage

// File: hw/rtl/scr_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_search: sequential slot scanner
// Steps one slot a cycle through the key memory, comparing each valid entry
// against the key and noting the first free slot on the way.
// ----------------------------------------------------------------------------
module scr_search
  import scr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KeyBits-1:0]  key,
  input  logic [Capacity-1:0] valid,
  input  logic [KeyBits-1:0]  rd_key,
  output logic [SlotBits-1:0] rd_addr,
  output logic                done,
  output scr_search_t         result
);

  logic                busy;
  logic                rd_pending;
  logic [SlotBits-1:0] cnt;
  logic [SlotBits-1:0] pend_slot;
  logic                last;

  assign rd_addr = cnt;

  // Walk the address, then compare the registered read in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rd_pending <= 1'b0;
      last <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      rd_pending <= busy;
      pend_slot <= cnt;
      last <= busy && (cnt == SlotBits'(Capacity - 1));
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        result <= '0;
      end else if (busy) begin
        if (cnt == SlotBits'(Capacity - 1)) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
      if (rd_pending) begin
        if (valid[pend_slot] && rd_key == key && !result.hit) begin
          result.hit <= 1'b1;
          result.hit_slot <= pend_slot;
        end
        if (!valid[pend_slot] && !result.free_found) begin
          result.free_found <= 1'b1;
          result.free_slot <= pend_slot;
        end
        if (last) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/second_chance_replacement_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_chance_replacement_top: second-chance replacement key store
// Fully associative store with FIFO order and a reference mark per entry.
// ----------------------------------------------------------------------------
// One item at a time. The lookup scans the key memory one slot per cycle
// through a single comparator. After the scan come the decision step and
// the output step; a hit or a remove that misses goes straight from one to
// the other. A remove that hits adds an unlink step, and an insert into a
// store with room adds an insert step. On a full store a miss adds an
// eviction step and a wait for the victim's key, then the insert, plus a
// move and a wait for each marked entry moved from tail to head before the
// victim is found. The result is held in an output register until taken;
// the next item is accepted once that register is free. No clearing pass
// is needed.
module second_chance_replacement_top
  import scr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scr_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scr_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CountBits-1:0] cfg_data
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SEARCH = 4'd1;
  localparam logic [3:0] ST_DECIDE = 4'd2;
  localparam logic [3:0] ST_WALK   = 4'd3;
  localparam logic [3:0] ST_EVRD   = 4'd4;
  localparam logic [3:0] ST_INSERT = 4'd5;
  localparam logic [3:0] ST_OUT    = 4'd6;
  localparam logic [3:0] ST_STEP   = 4'd7;
  localparam logic [3:0] ST_UNLINK = 4'd8;

  logic [3:0]           state;
  logic [CountBits-1:0] capacity_in_use;
  logic [CountBits-1:0] cap;
  logic [CountBits-1:0] occupancy;
  logic [SlotBits-1:0]  head_slot;
  logic [SlotBits-1:0]  tail_slot;
  logic [Capacity-1:0]  valid;
  logic [Capacity-1:0]  refd;
  logic [SlotBits-1:0]  up_link [Capacity];
  logic [SlotBits-1:0]  down_link [Capacity];
  logic [KeyBits-1:0]   key_mem [Capacity];
  logic [KeyBits-1:0]   rd_key;
  logic [SlotBits-1:0]  rd_addr;
  logic [SlotBits-1:0]  srch_addr;
  logic                 srch_start;
  logic                 srch_done;
  scr_search_t          srch;
  scr_in_t              cur;
  logic                 wr_en;
  logic [SlotBits-1:0]  wr_addr;
  logic [SlotBits-1:0]  victim;
  logic                 free_found;
  logic [SlotBits-1:0]  free_slot;
  logic [SlotBits-1:0]  link_addr;
  logic [SlotBits-1:0]  up_rd;
  logic [SlotBits-1:0]  down_rd;
  logic                 up_we;
  logic [SlotBits-1:0]  up_wa;
  logic [SlotBits-1:0]  up_wd;
  logic                 down_we;
  logic [SlotBits-1:0]  down_wa;
  logic [SlotBits-1:0]  down_wd;

  assign in_ready  = (state == ST_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  assign srch_start = in_valid && in_ready;

  // Effective capacity: zero acts as one, large values are clipped.
  always_comb begin
    cap = capacity_in_use;
    if (cap == '0) begin
      cap = CountBits'(1);
    end
    if (cap > CountBits'(Capacity)) begin
      cap = CountBits'(Capacity);
    end
  end

  scr_search u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (srch_start),
    .key     (cur.key),
    .valid   (valid),
    .rd_key  (rd_key),
    .rd_addr (srch_addr),
    .done    (srch_done),
    .result  (srch)
  );

  // Key memory: one write port, one registered read port.
  assign rd_addr = (state == ST_SEARCH) ? srch_addr : victim;
  assign wr_en   = (state == ST_INSERT);
  assign wr_addr = free_slot;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= cur.key;
    end
    rd_key <= key_mem[rd_addr];
  end

  // Link read address: the entry being removed, otherwise the tail.
  assign link_addr = (state == ST_DECIDE && cur.cmd == CMD_REMOVE) ?
                     srch.hit_slot : tail_slot;

  // Link writes for moving a marked tail entry, inserting and unlinking.
  always_comb begin
    up_we   = 1'b0;
    up_wa   = head_slot;
    up_wd   = tail_slot;
    down_we = 1'b0;
    down_wa = tail_slot;
    down_wd = head_slot;
    case (state)
      ST_STEP: begin
        if (refd[tail_slot] && occupancy != CountBits'(1)) begin
          up_we   = 1'b1;
          down_we = 1'b1;
        end
      end
      ST_INSERT: begin
        if (free_found && occupancy != '0) begin
          up_we   = 1'b1;
          up_wd   = free_slot;
          down_we = 1'b1;
          down_wa = free_slot;
        end
      end
      ST_UNLINK: begin
        if (occupancy != CountBits'(1) && srch.hit_slot != head_slot &&
            srch.hit_slot != tail_slot) begin
          up_we   = 1'b1;
          up_wa   = down_rd;
          up_wd   = up_rd;
          down_we = 1'b1;
          down_wa = up_rd;
          down_wd = down_rd;
        end
      end
      default: begin
      end
    endcase
  end

  // Link memories: one write port and one registered read port each.
  always_ff @(posedge clk) begin
    if (up_we) begin
      up_link[up_wa] <= up_wd;
    end
    if (down_we) begin
      down_link[down_wa] <= down_wd;
    end
    up_rd <= up_link[link_addr];
    down_rd <= down_link[link_addr];
  end

  // Sequencer and FIFO order update.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      capacity_in_use <= CountBits'(Capacity);
      occupancy <= '0;
      head_slot <= '0;
      tail_slot <= '0;
      valid <= '0;
      refd <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity_in_use <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (srch_start) begin
            cur <= in_data;
            out_data <= '0;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (srch_done) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          out_data.hit <= srch.hit;
          free_found <= srch.free_found;
          free_slot <= srch.free_slot;
          state <= ST_OUT;
          if (cur.cmd == CMD_ACCESS) begin
            if (srch.hit) begin
              refd[srch.hit_slot] <= 1'b1;
            end else if (occupancy >= cap && occupancy != '0) begin
              state <= ST_STEP;
            end else begin
              state <= ST_INSERT;
            end
          end else if (cur.cmd == CMD_REMOVE && srch.hit) begin
            out_data.removed <= 1'b1;
            state <= ST_UNLINK;
          end
        end
        ST_UNLINK: begin
          // The neighbours of the removed entry have been read; close the gap.
          valid[srch.hit_slot] <= 1'b0;
          refd[srch.hit_slot] <= 1'b0;
          if (occupancy != CountBits'(1)) begin
            if (srch.hit_slot == head_slot) begin
              head_slot <= down_rd;
            end else if (srch.hit_slot == tail_slot) begin
              tail_slot <= up_rd;
            end
          end
          occupancy <= occupancy - 1'b1;
          state <= ST_OUT;
        end
        ST_WALK: begin
          // Wait for the links of the new tail to be read.
          state <= ST_STEP;
        end
        ST_STEP: begin
          // Marked tail entry moves to the head, otherwise it is the victim.
          if (refd[tail_slot]) begin
            refd[tail_slot] <= 1'b0;
            if (occupancy != CountBits'(1)) begin
              tail_slot <= up_rd;
              head_slot <= tail_slot;
            end
            state <= ST_WALK;
          end else begin
            victim <= tail_slot;
            valid[tail_slot] <= 1'b0;
            if (occupancy != CountBits'(1)) begin
              tail_slot <= up_rd;
            end
            occupancy <= occupancy - 1'b1;
            free_found <= 1'b1;
            if (!free_found) begin
              free_slot <= tail_slot;
            end
            state <= ST_EVRD;
          end
        end
        ST_EVRD: begin
          // Wait for the victim's key to be read.
          out_data.evicted_valid <= 1'b1;
          state <= (occupancy < cap) ? ST_INSERT : ST_OUT;
        end
        ST_INSERT: begin
          if (state == ST_INSERT && out_data.evicted_valid == 1'b1) begin
            out_data.evicted_key <= rd_key;
          end
          if (free_found) begin
            valid[free_slot] <= 1'b1;
            refd[free_slot] <= 1'b0;
            if (occupancy == '0) begin
              tail_slot <= free_slot;
            end
            head_slot <= free_slot;
            occupancy <= occupancy + 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_data.evicted_valid && out_data.evicted_key == '0) begin
            out_data.evicted_key <= rd_key;
          end
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
